### src/aasid_pkg.sv
// Package for the 8-bit add/subtract/increment/decrement unit.
// Holds the command codes and the state and result structs.
// No dependencies.
package aasid_pkg;

    typedef enum logic [2:0] {
        CMD_ADC     = 3'd0,
        CMD_SBC     = 3'd1,
        CMD_INC_MEM = 3'd2,
        CMD_DEC_MEM = 3'd3,
        CMD_INX     = 3'd4,
        CMD_INY     = 3'd5,
        CMD_DEX     = 3'd6,
        CMD_DEY     = 3'd7
    } cmd_t;

    typedef struct packed {
        logic carry;
        logic zero;
        logic overflow;
        logic negative;
    } flags_t;

    typedef struct packed {
        logic [7:0] accumulator;
        logic [7:0] index_x;
        logic [7:0] index_y;
        flags_t     flags;
    } arch_state_t;

    typedef struct packed {
        logic [7:0]  result_value;
        logic        mem_write;
        logic [15:0] write_address;
        flags_t      flags;
    } result_t;

endpackage

### src/aasid_exec.sv
// Execute logic: computes the result beat and the next register/flag state
// for one command. Purely combinational. Depends on aasid_pkg.
module aasid_exec
    import aasid_pkg::*;
(
    input  cmd_t        cmd,
    input  logic [7:0]  operand,
    input  logic [15:0] mem_address,
    input  arch_state_t state_cur,
    output arch_state_t state_new,
    output result_t     res
);

    logic [7:0] add_b;
    logic [8:0] sum;
    logic [7:0] r;
    logic       sub_op;

    // SBC is ADC with the operand inverted; carry in is the inverted borrow.
    assign sub_op = (cmd == CMD_SBC);
    assign add_b  = sub_op ? ~operand : operand;
    assign sum    = {1'b0, state_cur.accumulator} + {1'b0, add_b}
                    + {8'd0, state_cur.flags.carry};

    always_comb
    begin
        state_new           = state_cur;
        res.mem_write       = 1'b0;
        res.write_address   = 16'd0;
        case (cmd)
            CMD_ADC, CMD_SBC:
            begin
                r = sum[7:0];
                state_new.accumulator    = r;
                state_new.flags.carry    = sum[8];
                state_new.flags.overflow = (state_cur.accumulator[7] ^ r[7])
                                           & (add_b[7] ^ r[7]);
            end
            CMD_INC_MEM:
            begin
                r = operand + 8'd1;
                res.mem_write     = 1'b1;
                res.write_address = mem_address;
            end
            CMD_DEC_MEM:
            begin
                r = operand - 8'd1;
                res.mem_write     = 1'b1;
                res.write_address = mem_address;
            end
            CMD_INX:
            begin
                r = state_cur.index_x + 8'd1;
                state_new.index_x = r;
            end
            CMD_INY:
            begin
                r = state_cur.index_y + 8'd1;
                state_new.index_y = r;
            end
            CMD_DEX:
            begin
                r = state_cur.index_x - 8'd1;
                state_new.index_x = r;
            end
            CMD_DEY:
            begin
                r = state_cur.index_y - 8'd1;
                state_new.index_y = r;
            end
            default:
            begin
                r = 8'd0;
            end
        endcase
        state_new.flags.zero     = (r == 8'd0);
        state_new.flags.negative = r[7];
        res.result_value = r;
        res.flags        = state_new.flags;
    end

endmodule

### src/alu_add_sub_inc_dec_8bit_top.sv
// Top level of the 8-bit add/subtract/increment/decrement unit.
// Input register, execute logic and result register. Depends on aasid_pkg
// and aasid_exec.
//
//  channel | signals                          | contents
//  --------+----------------------------------+--------------------------------
//  s_*     | s_tvalid s_tready s_tdata s_tuser | command, operand, address
//  m_*     | m_tvalid m_tready m_tdata m_tuser | result, address, flags, write
//
// Each beat passes through the input register and then the result register;
// one beat is taken every cycle while m_tready does not stall the result.
// The execute step (one 9-bit add and flag logic) lies between the two.
// Reset clears the accumulator, index registers and flags and empties both
// registers. A stall on m_tready holds the result; one further beat may wait
// in the input register, then s_tready drops.
module alu_add_sub_inc_dec_8bit_top
    import aasid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // operand [7:0], mem_address [23:8]
    input  logic [2:0]  s_tuser,   // cmd [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_value [7:0], write_address [23:8],
                                   // carry [24], zero [25], overflow [26],
                                   // negative [27], zero fill [31:28]
    output logic        m_tuser    // mem_write [0]
);

    logic        in_valid_reg;
    cmd_t        cmd_reg;
    logic [7:0]  operand_reg;
    logic [15:0] addr_reg;

    logic        out_valid_reg;
    result_t     out_reg;

    arch_state_t state_reg;
    arch_state_t state_next;
    result_t     res_next;

    logic        exec_fire;

    assign exec_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || exec_fire;

    aasid_exec u_exec (
        .cmd         (cmd_reg),
        .operand     (operand_reg),
        .mem_address (addr_reg),
        .state_cur   (state_reg),
        .state_new   (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg     <= cmd_t'(s_tuser);
            operand_reg <= s_tdata[7:0];
            addr_reg    <= s_tdata[23:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.mem_write;
    assign m_tdata  = {4'd0, out_reg.flags.negative, out_reg.flags.overflow,
                       out_reg.flags.zero, out_reg.flags.carry,
                       out_reg.write_address, out_reg.result_value};

`ifndef SYNTHESIS
    // Register-only writes never carry an address.
    a_addr_zero_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[23:8] == 16'd0))
        else $error("write address nonzero on a non-memory result");

    // Zero and negative flags follow the delivered result.
    a_zn_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[25] == (m_tdata[7:0] == 8'd0))
                      && (m_tdata[27] == m_tdata[7])))
        else $error("zero/negative flag does not match result");

    // Increment and decrement commands leave carry and overflow alone.
    a_cv_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && cmd_reg != CMD_ADC && cmd_reg != CMD_SBC)
        |=> (state_reg.flags.carry == $past(state_reg.flags.carry)
             && state_reg.flags.overflow == $past(state_reg.flags.overflow)))
        else $error("carry or overflow changed by inc/dec");

    // Architectural state changes only when a command executes.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> $stable(state_reg))
        else $error("state changed without an executed command");

    // Only memory commands raise the write flag.
    a_mem_write_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> (m_tuser == ($past(cmd_reg) == CMD_INC_MEM
                                   || $past(cmd_reg) == CMD_DEC_MEM)))
        else $error("mem_write does not match command");
`endif

endmodule

### sim/tb.sv
// Testbench for alu_add_sub_inc_dec_8bit_top: directed and random instruction beats
// are checked against a cycle-free model of the accumulator, index registers and flags.
// Depends on aasid_pkg and the RTL of the top level.
module tb
    import aasid_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned RANDOM_BEATS = 1600;
    localparam int unsigned MAX_PRINTED = 30;

    class alu_scoreboard;
        logic [7:0]  acc;
        logic [7:0]  idx_x;
        logic [7:0]  idx_y;
        flags_t      flg;
        result_t     expected_q[$];
        int unsigned mismatches;

        function new();
            acc = 8'h00;
            idx_x = 8'h00;
            idx_y = 8'h00;
            flg = '0;
            mismatches = 0;
        endfunction

        // Executes one instruction on the model state and returns the result beat.
        function result_t execute(cmd_t cmd, logic [7:0] opnd, logic [15:0] addr);
            result_t    res;
            logic [8:0] wide;
            logic [7:0] r;
            logic       borrow;
            res = '0;
            r = 8'h00;
            case (cmd)
                CMD_ADC:
                begin
                    wide = {1'b0, acc} + {1'b0, opnd} + {8'd0, flg.carry};
                    r = wide[7:0];
                    flg.carry = wide[8];
                    flg.overflow = ((acc ^ r) & (opnd ^ r) & 8'h80) != 8'h00;
                    acc = r;
                end
                CMD_SBC:
                begin
                    borrow = ~flg.carry;
                    wide = {1'b0, acc} - {1'b0, opnd} - {8'd0, borrow};
                    r = wide[7:0];
                    flg.carry = {1'b0, acc} >= ({1'b0, opnd} + {8'd0, borrow});
                    flg.overflow = (((acc ^ r) & 8'h80) != 8'h00) &&
                                   (((acc ^ opnd) & 8'h80) != 8'h00);
                    acc = r;
                end
                CMD_INC_MEM:
                begin
                    r = opnd + 8'd1;
                    res.mem_write = 1'b1;
                    res.write_address = addr;
                end
                CMD_DEC_MEM:
                begin
                    r = opnd - 8'd1;
                    res.mem_write = 1'b1;
                    res.write_address = addr;
                end
                CMD_INX:
                begin
                    idx_x = idx_x + 8'd1;
                    r = idx_x;
                end
                CMD_INY:
                begin
                    idx_y = idx_y + 8'd1;
                    r = idx_y;
                end
                CMD_DEX:
                begin
                    idx_x = idx_x - 8'd1;
                    r = idx_x;
                end
                default:
                begin
                    idx_y = idx_y - 8'd1;
                    r = idx_y;
                end
            endcase
            flg.zero = (r == 8'h00);
            flg.negative = r[7];
            res.result_value = r;
            res.flags = flg;
            return res;
        endfunction

        function void note_instr(cmd_t cmd, logic [7:0] opnd, logic [15:0] addr);
            expected_q.push_back(execute(cmd, opnd, addr));
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            if (mismatches < MAX_PRINTED)
                $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [31:0] data, logic wr);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report("result beat with nothing pending", data[15:0], 16'h0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (data[7:0] !== want.result_value)
                    report("result_value", 16'(data[7:0]), 16'(want.result_value));
                if (wr !== want.mem_write)
                    report("mem_write", 16'(wr), 16'(want.mem_write));
                if (data[23:8] !== want.write_address)
                    report("write_address", data[23:8], want.write_address);
                if (data[24] !== want.flags.carry)
                    report("carry", 16'(data[24]), 16'(want.flags.carry));
                if (data[25] !== want.flags.zero)
                    report("zero", 16'(data[25]), 16'(want.flags.zero));
                if (data[26] !== want.flags.overflow)
                    report("overflow", 16'(data[26]), 16'(want.flags.overflow));
                if (data[27] !== want.flags.negative)
                    report("negative", 16'(data[27]), 16'(want.flags.negative));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // operand [7:0], mem_address [23:8]
    logic [2:0]  s_tuser;    // cmd [2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // result_value [7:0], write_address [23:8], carry [24],
                             // zero [25], overflow [26], negative [27]
    logic        m_tuser;    // mem_write [0]

    alu_scoreboard board;
    int unsigned   cycles;
    bit            no_gaps;

    alu_add_sub_inc_dec_8bit_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_instr(cmd_t cmd, logic [7:0] opnd, logic [15:0] addr);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {addr, opnd};
        s_tuser <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_instr(cmd, opnd, addr);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side back-pressure.
    initial
    begin
        int unsigned stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial
    begin
        int unsigned n;
        cmd_t        cmd;
        logic [7:0]  opnd;
        logic [15:0] addr;
        board = new();
        cycles = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Add and subtract across the carry and sign boundaries.
        send_instr(CMD_ADC, 8'h00, 16'h0000);
        send_instr(CMD_ADC, 8'h7F, 16'hFFFF);
        send_instr(CMD_ADC, 8'h01, 16'h1234);
        send_instr(CMD_ADC, 8'hFF, 16'h0000);
        send_instr(CMD_ADC, 8'h00, 16'h0000);
        send_instr(CMD_SBC, 8'h01, 16'h0000);
        send_instr(CMD_SBC, 8'hFF, 16'hFFFF);
        send_instr(CMD_SBC, 8'h00, 16'h0000);
        send_instr(CMD_SBC, 8'h80, 16'h0000);
        // Memory increment and decrement, including wrap in both directions.
        send_instr(CMD_INC_MEM, 8'hFF, 16'hFFFF);
        send_instr(CMD_INC_MEM, 8'h7F, 16'h0000);
        send_instr(CMD_DEC_MEM, 8'h00, 16'hA5A5);
        send_instr(CMD_DEC_MEM, 8'h01, 16'h5A5A);
        send_instr(CMD_DEC_MEM, 8'h80, 16'h8001);
        // Index registers wrap; operand and address must be ignored.
        send_instr(CMD_DEX, 8'hFF, 16'hFFFF);
        send_instr(CMD_INX, 8'h00, 16'h0000);
        send_instr(CMD_INX, 8'hAA, 16'h5555);
        send_instr(CMD_DEY, 8'h00, 16'h0000);
        send_instr(CMD_INY, 8'hFF, 16'hFFFF);
        send_instr(CMD_INY, 8'h55, 16'hAAAA);
        send_instr(CMD_ADC, 8'h80, 16'h0000);
        send_instr(CMD_ADC, 8'h80, 16'h0000);

        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            // Every fourth stretch runs with no idling on either side.
            no_gaps = ((n / 200) % 4) == 3;
            cmd = cmd_t'($urandom_range(0, 7));
            case ($urandom_range(0, 7))
                0: opnd = 8'h00;
                1: opnd = 8'hFF;
                2: opnd = 8'h7F;
                3: opnd = 8'h80;
                default: opnd = 8'($urandom);
            endcase
            addr = 16'($urandom);
            send_instr(cmd, opnd, addr);
        end
        no_gaps = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
